>>> rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TTB_ASSERT_CLK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checked on every clock edge, reset included.
`define TTB_ASSERT_ANY(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

>>> rtl/core/ttb_pkg.sv
// Shared widths and control types of the tangent/binormal core.
`timescale 1ns / 1ps
package ttb_pkg;
  localparam int PosW    = 24;
  localparam int TexW    = 17;
  localparam int OutW    = 16;
  localparam int EdgeW   = PosW + 1;
  localparam int DeltaW  = TexW + 1;
  localparam int ProdW   = EdgeW + DeltaW;
  localparam int TermW   = ProdW + 1;
  localparam int NormBits  = 30;
  localparam int SqW       = 2 * NormBits;
  localparam int SumW      = SqW + 2;
  localparam int LenW      = NormBits + 1;
  localparam int QuotW     = 15;
  localparam int UnitShift = 14;
  localparam int NumW      = NormBits + UnitShift + 1;
  localparam int NumTerms  = 14;

  typedef struct packed {
    logic start;
    logic neg;
  } ttb_norm_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } ttb_norm_rsp_t;
endpackage

>>> rtl/core/ttb_norm.sv
// Iterative vector normalizer: scale, sum of squares, integer root, three divides.
`timescale 1ns / 1ps
module ttb_norm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttb_pkg::ttb_norm_req_t              req,
  input  logic signed [ttb_pkg::TermW-1:0]    vec_x,
  input  logic signed [ttb_pkg::TermW-1:0]    vec_y,
  input  logic signed [ttb_pkg::TermW-1:0]    vec_z,
  output ttb_pkg::ttb_norm_rsp_t              rsp,
  output logic signed [ttb_pkg::OutW-1:0]     unit_x,
  output logic signed [ttb_pkg::OutW-1:0]     unit_y,
  output logic signed [ttb_pkg::OutW-1:0]     unit_z
);
  import ttb_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_ROOT  = 6'b001000,
    N_PREP  = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_t;

  nstate_t                 state_r;
  logic                    done_r;
  logic                    zero_r;
  logic [TermW-1:0]        mag_r [3];
  logic                    flip_r [3];
  logic [3:0]              cnt_r;
  logic [1:0]              comp_r;
  logic [SqW-1:0]          prod_r;
  logic [SumW-1:0]         sum_r;
  logic [SumW-1:0]         rootn_r;
  logic [SumW-1:0]         root_r;
  logic [SumW-1:0]         bit_r;
  logic [LenW-1:0]         len_r;
  logic [LenW-1:0]         rem_r;
  logic [QuotW-1:0]        lo_r;
  logic [QuotW-1:0]        q_r;
  logic signed [OutW-1:0]  unit_r [3];

  logic [TermW-1:0]        orv;
  logic [NormBits-1:0]     sq_op;
  logic [SqW-1:0]          sq_prod;
  logic [SumW-1:0]         trial_sum;
  logic                    root_ge;
  logic [SumW-1:0]         root_nxt;
  logic [TermW-1:0]        div_mag;
  logic [NumW-1:0]         num;
  logic [LenW:0]           div_trial;
  logic                    div_ge;
  logic [LenW:0]           div_diff;
  logic [QuotW-1:0]        q_nxt;
  logic signed [OutW-1:0]  q_mag;
  logic signed [OutW-1:0]  unit_nxt;
  logic                    last_step;

  assign orv = mag_r[0] | mag_r[1] | mag_r[2];

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = mag_r[0][NormBits-1:0];
      2'd1:    sq_op = mag_r[1][NormBits-1:0];
      default: sq_op = mag_r[2][NormBits-1:0];
    endcase
  end
  assign sq_prod = sq_op * sq_op;

  assign trial_sum = root_r + bit_r;
  assign root_ge   = rootn_r >= trial_sum;
  assign root_nxt  = root_ge ? (root_r >> 1) + bit_r : root_r >> 1;

  always_comb begin
    case (comp_r)
      2'd0:    div_mag = mag_r[0];
      2'd1:    div_mag = mag_r[1];
      default: div_mag = mag_r[2];
    endcase
  end

  // Numerator a*2^14 + floor(L/2), so that halves round away from zero.
  assign num = {1'b0, div_mag[NormBits-1:0], {UnitShift{1'b0}}} + NumW'(len_r >> 1);

  assign div_trial = {rem_r, lo_r[QuotW-1]};
  assign div_ge    = div_trial >= {1'b0, len_r};
  assign div_diff  = div_ge ? div_trial - {1'b0, len_r} : div_trial;
  assign q_nxt     = {q_r[QuotW-2:0], div_ge};
  assign q_mag     = $signed({1'b0, q_nxt});
  assign unit_nxt  = flip_r[comp_r] ? -q_mag : q_mag;

  // The run ends on a null vector or after the last divide step of the third component.
  assign last_step = ((state_r == N_SHIFT) && (orv == '0)) ||
                     ((state_r == N_DIV) && (cnt_r == 4'd0) && (comp_r == 2'd2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      done_r <= last_step;
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            mag_r[0]  <= vec_x[TermW-1] ? $unsigned(-vec_x) : $unsigned(vec_x);
            mag_r[1]  <= vec_y[TermW-1] ? $unsigned(-vec_y) : $unsigned(vec_y);
            mag_r[2]  <= vec_z[TermW-1] ? $unsigned(-vec_z) : $unsigned(vec_z);
            flip_r[0] <= vec_x[TermW-1] ^ req.neg;
            flip_r[1] <= vec_y[TermW-1] ^ req.neg;
            flip_r[2] <= vec_z[TermW-1] ^ req.neg;
            state_r   <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // One bit a cycle until the largest magnitude has exactly 30 bits.
          if (orv == '0) begin
            zero_r  <= 1'b1;
            state_r <= N_IDLE;
          end else if (|orv[TermW-1:NormBits]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!orv[NormBits-1]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          prod_r <= sq_prod;
          cnt_r  <= cnt_r + 4'd1;
          if (cnt_r != 4'd0) sum_r <= sum_r + SumW'(prod_r);
          if (cnt_r == 4'd3) begin
            rootn_r <= sum_r + SumW'(prod_r);
            root_r  <= '0;
            bit_r   <= SumW'(1) << (SumW - 2);
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (root_ge) rootn_r <= rootn_r - trial_sum;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          if (bit_r == SumW'(1)) begin
            len_r   <= root_nxt[LenW-1:0];
            comp_r  <= '0;
            state_r <= N_PREP;
          end
        end
        N_PREP: begin
          rem_r   <= LenW'(num >> QuotW);
          lo_r    <= num[QuotW-1:0];
          q_r     <= '0;
          cnt_r   <= 4'(QuotW - 1);
          state_r <= N_DIV;
        end
        N_DIV: begin
          rem_r <= div_diff[LenW-1:0];
          lo_r  <= lo_r << 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) begin
            unit_r[comp_r] <= unit_nxt;
            if (comp_r == 2'd2) begin
              zero_r  <= 1'b0;
              state_r <= N_IDLE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= N_PREP;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;
  assign unit_x   = unit_r[0];
  assign unit_y   = unit_r[1];
  assign unit_z   = unit_r[2];
endmodule

>>> rtl/core/triangle_tangent_binormal_core.sv
// Top level of the per-triangle tangent and binormal core.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  corner x/y/z (s7.16), tex u/v (Q1.16)
//   out      source     out_valid/out_stall tangent, binormal (s1.14), degenerate
//
// The first two corners of a triangle are only stored. The third corner starts the
// products on the shared 25x18 multiplier; then the shared normalizer runs for the
// tangent and, unless that is null, the binormal; each run is the one-bit-a-cycle
// scaling shift (up to 29 steps), the 31-step integer root and three divides, then
// the output register is loaded. A zero determinant skips the normalizer.
// Reset (rst_n low, synchronous) clears the corner count and the output valid.
// A stalled result waits in the output register while corners keep coming in.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_tangent_binormal_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ttb_pkg::PosW-1:0]    in_corner_x,
  input  logic signed [ttb_pkg::PosW-1:0]    in_corner_y,
  input  logic signed [ttb_pkg::PosW-1:0]    in_corner_z,
  input  logic [ttb_pkg::TexW-1:0]           in_tex_u,
  input  logic [ttb_pkg::TexW-1:0]           in_tex_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ttb_pkg::OutW-1:0]    out_tangent_x,
  output logic signed [ttb_pkg::OutW-1:0]    out_tangent_y,
  output logic signed [ttb_pkg::OutW-1:0]    out_tangent_z,
  output logic signed [ttb_pkg::OutW-1:0]    out_binormal_x,
  output logic signed [ttb_pkg::OutW-1:0]    out_binormal_y,
  output logic signed [ttb_pkg::OutW-1:0]    out_binormal_z,
  output logic                               out_degenerate
);
  import ttb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_NORM_T = 5'b00100,
    S_NORM_B = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                   state_r;
  logic [1:0]               count_r;
  logic signed [PosW-1:0]   p0_r [3];
  logic signed [PosW-1:0]   p1_r [3];
  logic [TexW-1:0]          u0_r, v0_r, u1_r, v1_r;
  logic signed [EdgeW-1:0]  e0_r [3];
  logic signed [EdgeW-1:0]  e1_r [3];
  logic signed [DeltaW-1:0] du0_r, dv0_r, du1_r, dv1_r;
  logic [3:0]               ms_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [ProdW-1:0]  first_r;
  logic signed [TermW-1:0]  term_r [7];
  logic signed [OutW-1:0]   tan_r [3];
  logic                     deg_r;
  logic                     out_valid_r;
  logic signed [OutW-1:0]   out_t_r [3];
  logic signed [OutW-1:0]   out_b_r [3];
  logic                     out_deg_r;

  logic                     in_acc;
  logic signed [PosW-1:0]   cp [3];
  logic signed [EdgeW-1:0]  mul_a;
  logic signed [DeltaW-1:0] mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic [3:0]               hidx;
  logic signed [TermW-1:0]  term_diff;
  logic                     det_zero;
  logic                     mul_last;
  ttb_norm_req_t            nreq;
  ttb_norm_rsp_t            nrsp;
  logic signed [TermW-1:0]  nvec_x, nvec_y, nvec_z;
  logic signed [OutW-1:0]   unit_x, unit_y, unit_z;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign cp[0]    = in_corner_x;
  assign cp[1]    = in_corner_y;
  assign cp[2]    = in_corner_z;

  // Term order: det, then t as pairs per axis, then b as pairs per axis.
  always_comb begin
    case (ms_r)
      4'd0:    begin mul_a = EdgeW'(du0_r); mul_b = dv1_r; end
      4'd1:    begin mul_a = EdgeW'(du1_r); mul_b = dv0_r; end
      4'd2:    begin mul_a = e0_r[0];       mul_b = dv1_r; end
      4'd3:    begin mul_a = e1_r[0];       mul_b = dv0_r; end
      4'd4:    begin mul_a = e0_r[1];       mul_b = dv1_r; end
      4'd5:    begin mul_a = e1_r[1];       mul_b = dv0_r; end
      4'd6:    begin mul_a = e0_r[2];       mul_b = dv1_r; end
      4'd7:    begin mul_a = e1_r[2];       mul_b = dv0_r; end
      4'd8:    begin mul_a = e1_r[0];       mul_b = du0_r; end
      4'd9:    begin mul_a = e0_r[0];       mul_b = du1_r; end
      4'd10:   begin mul_a = e1_r[1];       mul_b = du0_r; end
      4'd11:   begin mul_a = e0_r[1];       mul_b = du1_r; end
      4'd12:   begin mul_a = e1_r[2];       mul_b = du0_r; end
      4'd13:   begin mul_a = e0_r[2];       mul_b = du1_r; end
      default: begin mul_a = e0_r[0];       mul_b = dv1_r; end
    endcase
  end
  assign mul_p     = mul_a * mul_b;
  assign hidx      = ms_r - 4'd1;
  assign term_diff = TermW'(first_r) - TermW'(prod_r);
  assign det_zero  = term_r[0] == '0;
  assign mul_last  = (state_r == S_MUL) && (ms_r == 4'(NumTerms));

  assign nreq.start = (mul_last && !det_zero) ||
                      (state_r == S_NORM_T && nrsp.done && !nrsp.zero);
  assign nreq.neg   = term_r[0][TermW-1];
  assign nvec_x     = (state_r == S_MUL) ? term_r[1] : term_r[4];
  assign nvec_y     = (state_r == S_MUL) ? term_r[2] : term_r[5];
  assign nvec_z     = (state_r == S_MUL) ? term_r[3] : term_r[6];

  ttb_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (nreq),
    .vec_x  (nvec_x),
    .vec_y  (nvec_y),
    .vec_z  (nvec_z),
    .rsp    (nrsp),
    .unit_x (unit_x),
    .unit_y (unit_y),
    .unit_z (unit_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the done state the output load below decides the valid.
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!count_r[1]) begin
              if (!count_r[0]) begin
                for (int i = 0; i < 3; i++) p0_r[i] <= cp[i];
                u0_r <= in_tex_u;
                v0_r <= in_tex_v;
              end else begin
                for (int i = 0; i < 3; i++) p1_r[i] <= cp[i];
                u1_r <= in_tex_u;
                v1_r <= in_tex_v;
              end
              count_r <= count_r + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                e0_r[i] <= EdgeW'(p1_r[i]) - EdgeW'(p0_r[i]);
                e1_r[i] <= EdgeW'(cp[i]) - EdgeW'(p0_r[i]);
              end
              du0_r   <= $signed({1'b0, u1_r}) - $signed({1'b0, u0_r});
              dv0_r   <= $signed({1'b0, v1_r}) - $signed({1'b0, v0_r});
              du1_r   <= $signed({1'b0, in_tex_u}) - $signed({1'b0, u0_r});
              dv1_r   <= $signed({1'b0, in_tex_v}) - $signed({1'b0, v0_r});
              count_r <= '0;
              ms_r    <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // Product of one term registered while the previous one is combined.
          prod_r <= mul_p;
          ms_r   <= ms_r + 4'd1;
          if (ms_r != 4'd0) begin
            if (!hidx[0]) first_r <= prod_r;
            else term_r[hidx[3:1]] <= term_diff;
          end
          if (mul_last) begin
            if (det_zero) begin
              deg_r   <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_NORM_T;
            end
          end
        end
        S_NORM_T: begin
          if (nrsp.done) begin
            if (nrsp.zero) begin
              deg_r   <= 1'b1;
              state_r <= S_DONE;
            end else begin
              tan_r[0] <= unit_x;
              tan_r[1] <= unit_y;
              tan_r[2] <= unit_z;
              state_r  <= S_NORM_B;
            end
          end
        end
        S_NORM_B: begin
          if (nrsp.done) begin
            deg_r   <= nrsp.zero;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < 3; i++) out_t_r[i] <= deg_r ? '0 : tan_r[i];
            out_b_r[0]  <= deg_r ? '0 : unit_x;
            out_b_r[1]  <= deg_r ? '0 : unit_y;
            out_b_r[2]  <= deg_r ? '0 : unit_z;
            out_deg_r   <= deg_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tangent_x  = out_t_r[0];
  assign out_tangent_y  = out_t_r[1];
  assign out_tangent_z  = out_t_r[2];
  assign out_binormal_x = out_b_r[0];
  assign out_binormal_y = out_b_r[1];
  assign out_binormal_z = out_b_r[2];
  assign out_degenerate = out_deg_r;

  `TTB_ASSERT_CLK(a_valid_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result raised outside done state")
  `TTB_ASSERT_CLK(a_third_corner_starts, (in_acc && count_r[1]) |=> (state_r == S_MUL), "third corner did not start the products")
  `TTB_ASSERT_CLK(a_count_range, count_r != 2'd3, "corner count out of range")
  `TTB_ASSERT_ANY(a_reset_clears_valid, !rst_n |=> !out_valid_r, "reset did not clear the result valid")
endmodule

>>> dv/testbench.sv
// Self-checking testbench of the per-triangle tangent and binormal core.
`timescale 1ns / 1ps
module testbench;
  import ttb_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 1500;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PosW-1:0] in_corner_x = '0, in_corner_y = '0, in_corner_z = '0;
  logic [TexW-1:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OutW-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [OutW-1:0] out_binormal_x, out_binormal_y, out_binormal_z;
  logic out_degenerate;

  triangle_tangent_binormal_core dut (.*);

  always #1 clk = ~clk;

  // Expected results: {degenerate, tangent xyz, binormal xyz}.
  logic [6*OutW:0] basis_queue[$];
  longint held_pos[6];
  longint held_tex[4];
  int corner_idx = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scales a vector to unit length in s1.14; returns 0 for a null vector.
  function automatic bit unit_scale(input longint c[3], input bit flip,
                                    output logic [OutW-1:0] u[3]);
    longint unsigned mag[3], top, sum, len, r;
    int nb;
    top = 0;
    sum = 0;
    nb = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return 1'b0;
    while (top != 0) begin
      nb++;
      top >>= 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (nb > NormBits) mag[i] >>= (nb - NormBits);
      else mag[i] <<= (NormBits - nb);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      r = (mag[i] * 16384 + len / 2) / len;
      u[i] = OutW'(((c[i] < 0) != flip) ? -r : r);
    end
    return 1'b1;
  endfunction

  task automatic predict_corner(longint px, longint py, longint pz,
                                longint tu, longint tv);
    longint p[3], e0[3], e1[3], t[3], b[3], c[3];
    longint du0, dv0, du1, dv1, det;
    logic [OutW-1:0] tu_v[3], bv[3];
    bit ok;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    if (corner_idx < 2) begin
      for (int i = 0; i < 3; i++) held_pos[corner_idx*3+i] = p[i];
      held_tex[corner_idx*2] = tu;
      held_tex[corner_idx*2+1] = tv;
      corner_idx++;
      return;
    end
    corner_idx = 0;
    for (int i = 0; i < 3; i++) begin
      e0[i] = held_pos[3+i] - held_pos[i];
      e1[i] = p[i] - held_pos[i];
    end
    du0 = held_tex[2] - held_tex[0];
    dv0 = held_tex[3] - held_tex[1];
    du1 = tu - held_tex[0];
    dv1 = tv - held_tex[1];
    det = du0 * dv1 - du1 * dv0;
    for (int i = 0; i < 3; i++) begin
      t[i] = dv1 * e0[i] - dv0 * e1[i];
      b[i] = du0 * e1[i] - du1 * e0[i];
    end
    ok = (det != 0);
    if (ok) ok = unit_scale(t, det < 0, tu_v);
    if (ok) ok = unit_scale(b, det < 0, bv);
    if (ok) basis_queue.push_back({1'b0, tu_v[0], tu_v[1], tu_v[2], bv[0], bv[1], bv[2]});
    else basis_queue.push_back({1'b1, {6*OutW{1'b0}}});
  endtask

  task automatic send_corner(logic [PosW-1:0] x, logic [PosW-1:0] y,
                             logic [PosW-1:0] z, logic [TexW-1:0] u,
                             logic [TexW-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_corner_x <= x;
    in_corner_y <= y;
    in_corner_z <= z;
    in_tex_u <= u;
    in_tex_v <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_corner($signed(x), $signed(y), $signed(z), u, v);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_triangle_random();
    logic [PosW-1:0] base[3];
    logic [TexW-1:0] u0, v0;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) base[i] = PosW'($urandom);
    u0 = TexW'($urandom_range(65536));
    v0 = TexW'($urandom_range(65536));
    for (int k = 0; k < 3; k++) begin
      logic [PosW-1:0] p[3];
      logic [TexW-1:0] u, v;
      for (int i = 0; i < 3; i++)
        p[i] = (mode < 4) ? PosW'(base[i] + $urandom_range(2047) - 1024)
                          : PosW'($urandom);
      u = (mode == 9) ? TexW'($urandom) : TexW'($urandom_range(65536));
      v = (mode == 9) ? TexW'($urandom) : TexW'($urandom_range(65536));
      // A repeated texture coordinate makes the determinant zero.
      if (mode == 8 && k == 2) begin
        u = u0;
        v = v0;
      end
      if (k == 0) begin
        u = u0;
        v = v0;
      end
      send_corner(p[0], p[1], p[2], u, v);
    end
  endtask

  task automatic test_directed();
    // Extreme positions against extreme texture coordinates.
    send_corner(24'h800000, 24'h7FFFFF, 24'h000000, 17'd0, 17'd0);
    send_corner(24'h7FFFFF, 24'h800000, 24'h800000, 17'd65536, 17'd0);
    send_corner(24'h000000, 24'h000000, 24'h7FFFFF, 17'd0, 17'd65536);
    // Texture values above one.
    send_corner(24'h000001, 24'hFFFFFF, 24'h123456, 17'h1FFFF, 17'h00000);
    send_corner(24'hFFFFFF, 24'h000001, 24'hABCDEF, 17'h00000, 17'h1FFFF);
    send_corner(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 17'h1FFFF, 17'h1FFFF);
    // Zero determinant: all three texture coordinates equal.
    send_corner(24'h010000, 24'h020000, 24'h030000, 17'd100, 17'd200);
    send_corner(24'h050000, 24'h060000, 24'h070000, 17'd100, 17'd200);
    send_corner(24'h090000, 24'h0A0000, 24'h0B0000, 17'd100, 17'd200);
    // Zero-length vectors: all corners at one point, valid texture.
    send_corner(24'h012345, 24'h012345, 24'h012345, 17'd0, 17'd0);
    send_corner(24'h012345, 24'h012345, 24'h012345, 17'd1000, 17'd0);
    send_corner(24'h012345, 24'h012345, 24'h012345, 17'd0, 17'd1000);
    // Smallest nonzero edges and deltas.
    send_corner(24'h000000, 24'h000000, 24'h000000, 17'd5, 17'd5);
    send_corner(24'h000001, 24'h000000, 24'h000000, 17'd6, 17'd5);
    send_corner(24'h000000, 24'h000001, 24'h000000, 17'd5, 17'd4);
    // Texture mirrored in both axes, which leaves the determinant positive.
    send_corner(24'hFF0000, 24'h000000, 24'h000000, 17'd65536, 17'd65536);
    send_corner(24'h010000, 24'h000000, 24'h000000, 17'd0, 17'd65536);
    send_corner(24'h000000, 24'h010000, 24'h000000, 17'd65536, 17'd0);
  endtask

  task automatic test_random(int tris, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (tris) send_triangle_random();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HoldCycles;
    repeat (10) send_triangle_random();
  endtask

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      logic [6*OutW:0] got, want;
      got = {out_degenerate, out_tangent_x, out_tangent_y, out_tangent_z,
             out_binormal_x, out_binormal_y, out_binormal_z};
      if (basis_queue.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, got);
        errors++;
      end else begin
        want = basis_queue.pop_front();
        if (got[6*OutW] !== want[6*OutW]) begin
          $display("%0t: degenerate expected %0d actual %0d", $time,
                   want[6*OutW], got[6*OutW]);
          errors++;
        end
        for (int f = 0; f < 6; f++) begin
          if (got[f*OutW +: OutW] !== want[f*OutW +: OutW]) begin
            $display("%0t: vector field %0d expected %0d actual %0d", $time, 5 - f,
                     $signed(want[f*OutW +: OutW]), $signed(got[f*OutW +: OutW]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(140, 17, 73);
    test_random(140, 73, 17);
    test_random(140, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    recv_idle_pct = 20;
    while (basis_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ttb_pkg.sv
rtl/core/ttb_norm.sv
rtl/core/triangle_tangent_binormal_core.sv
dv/testbench.sv
